[src/scfd_pkg.sv]
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared types, constants and the crc helper for the sync crc frame deframer.
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int STORE_BYTES = 64;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int MAX_PAYLOAD = 32;
  localparam int HDR_BYTES   = 4;
  localparam int CRC_BYTES   = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_RST = 8'hA5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYNC_RD,
    ST_SYNC_CK,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_CRC_START,
    ST_CRC_RUN,
    ST_CRC_HI,
    ST_CRC_CMP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  // one byte of crc16-ccitt, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[src/sync_crc_frame_deframer.sv]
// ----------------------------------------------------------------------------
// sync_crc_frame_deframer
// Byte stream deframer: sync byte, type, le length, payload, le crc16-ccitt.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_data_byte
//  out_    | output    | out_valid/out_stall | type, length, index, byte, flags
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_sync_byte
//
// Each leading byte dropped by the sync scan costs a store read and a compare;
// the header, the crc pass over type, length and payload, and each payload
// result (held while out_stall is high) are read byte by byte from the store.
// Reset (synchronous, rst_n low) empties the store; its contents stay unknown.
// A result stalled on out_ holds the block; no input is taken until done.
// ----------------------------------------------------------------------------
module sync_crc_frame_deframer
  import scfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_type,
  output logic [5:0] out_payload_length,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_sync_byte
);

  state_t state_r, state_nxt;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] head_r;
  logic [AW:0]   cnt_r;
  logic [7:0]    sync_r;
  logic [5:0]    plen_r;
  logic [15:0]   plen16;
  logic [5:0]    idx_r;
  logic [4:0]    k_r;
  logic [15:0]   crc_r;
  logic [7:0]    crc_lo_r;
  logic [7:0]    len_lo_r;
  logic [7:0]    type_r;
  logic          in_acc, out_acc, full, out_end;
  logic [AW:0]   total;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign full      = (cnt_r == (AW+1)'(STORE_BYTES));
  assign plen16    = {rd_data_r, len_lo_r};
  assign total     = (AW+1)'(plen_r) + (AW+1)'(HDR_BYTES + CRC_BYTES);
  assign out_end   = (plen_r == 6'd0) || ((6'(k_r) + 6'd1) == plen_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) sync_r <= SYNC_RST;
    else if (cfg_valid && cfg_ready) sync_r <= cfg_sync_byte;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_acc) state_nxt = ST_SYNC_RD;
      ST_SYNC_RD:   state_nxt = (cnt_r == '0) ? ST_IDLE : ST_SYNC_CK;
      ST_SYNC_CK: begin
        if (rd_data_r != sync_r) state_nxt = ST_SYNC_RD;
        else if (cnt_r < (AW+1)'(HDR_BYTES)) state_nxt = ST_IDLE;
        else state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO:    state_nxt = ST_LEN_HI;
      ST_LEN_HI: begin
        if (plen16 > 16'(MAX_PAYLOAD)) state_nxt = ST_SYNC_RD;
        else if (cnt_r < (AW+1)'(plen16[5:0]) + (AW+1)'(HDR_BYTES + CRC_BYTES))
          state_nxt = ST_IDLE;
        else state_nxt = ST_CRC_START;
      end
      ST_CRC_START: state_nxt = ST_CRC_RUN;
      ST_CRC_RUN:   if (idx_r == plen_r + 6'd3) state_nxt = ST_CRC_HI;
      ST_CRC_HI:    state_nxt = ST_CRC_CMP;
      ST_CRC_CMP:   state_nxt = ({rd_data_r, crc_lo_r} == crc_r) ? ST_OUT_RD : ST_SYNC_RD;
      ST_OUT_RD:    state_nxt = ST_OUT_LD;
      ST_OUT_LD:    state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT:  if (out_acc) state_nxt = out_end ? ST_IDLE : ST_OUT_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs: read address and input stall
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_SYNC_CK:   rd_addr = head_r + AW'(2);
      ST_LEN_LO:    rd_addr = head_r + AW'(3);
      ST_CRC_START: rd_addr = head_r + AW'(1);
      ST_CRC_RUN:   rd_addr = head_r + AW'(idx_r) + AW'(1);
      ST_CRC_HI:    rd_addr = head_r + AW'(plen_r) + AW'(5);
      ST_OUT_RD:    rd_addr = head_r + AW'(k_r) + AW'(HDR_BYTES);
      default:      rd_addr = head_r;
    endcase
  end

  // byte store
  always_ff @(posedge clk) begin
    if (in_acc) mem[head_r + (full ? AW'(0) : cnt_r[AW-1:0])] <= in_data_byte;
    rd_data_r <= mem[rd_addr];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (in_acc) cnt_r <= full ? (AW+1)'(1) : cnt_r + 1'b1;
        ST_SYNC_CK: if (rd_data_r != sync_r) begin
          head_r <= head_r + 1'b1;
          cnt_r  <= cnt_r - 1'b1;
        end
        ST_LEN_HI: if (plen16 > 16'(MAX_PAYLOAD)) begin
          head_r <= head_r + 1'b1;
          cnt_r  <= cnt_r - 1'b1;
        end
        ST_CRC_CMP: if ({rd_data_r, crc_lo_r} != crc_r) begin
          head_r <= head_r + 1'b1;
          cnt_r  <= cnt_r - 1'b1;
        end
        ST_OUT_LD: out_valid <= 1'b1;
        ST_OUT_WAIT: if (out_acc) begin
          out_valid <= 1'b0;
          if (out_end) begin
            head_r <= head_r + total[AW-1:0];
            cnt_r  <= cnt_r - total;
          end
        end
        default: ;
      endcase
    end
  end

  // header, crc and result payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LEN_LO: len_lo_r <= rd_data_r;
      ST_LEN_HI: plen_r <= plen16[5:0];
      ST_CRC_START: begin
        idx_r <= 6'd1;
        crc_r <= CRC_INIT;
        k_r   <= '0;
      end
      ST_CRC_RUN: begin
        crc_r <= crc_byte(crc_r, rd_data_r);
        idx_r <= idx_r + 6'd1;
        if (idx_r == 6'd1) type_r <= rd_data_r;
      end
      ST_CRC_HI: crc_lo_r <= rd_data_r;
      ST_OUT_LD: begin
        out_frame_type     <= type_r;
        out_payload_length <= plen_r;
        out_byte_index     <= k_r;
        out_has_byte       <= (plen_r != 6'd0);
        out_payload_byte   <= (plen_r != 6'd0) ? rd_data_r : 8'd0;
        out_last           <= out_end;
      end
      ST_OUT_WAIT: if (out_acc) k_r <= k_r + 5'd1;
      default: ;
    endcase
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(STORE_BYTES)) else $error("fill count above store size");
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT_WAIT) else $error("result outside output wait");
  a_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SYNC_RD) else $error("accepted byte not scanned");
`endif

endmodule
